// ----- sv/rppc_pkg.sv -----
// ----------------------------------------------------------------------------
// rppc_pkg
// Shared constants and helpers for the regular polygon point clamp.
// ----------------------------------------------------------------------------
package rppc_pkg;

    localparam int K_W   = 20;
    localparam int E_W   = 21;
    localparam int Q_W   = 22;
    localparam int D_W   = 28;
    localparam int W_W   = 30;
    localparam int M_W   = 34;
    localparam int P_W   = 64;
    localparam int R_W   = 18;
    localparam int N_W   = 7;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_CENTER_X  = 3'd0;
    localparam logic [IDX_W-1:0] REG_CENTER_Y  = 3'd1;
    localparam logic [IDX_W-1:0] REG_RADIUS_X  = 3'd2;
    localparam logic [IDX_W-1:0] REG_RADIUS_Y  = 3'd3;
    localparam logic [IDX_W-1:0] REG_CORNERS   = 3'd4;

    localparam logic [31:0] TRIG_A       = 32'd1686629713;
    localparam logic [31:0] TRIG_B       = 32'd688904866;
    localparam logic [31:0] TRIG_C       = 32'd76016977;
    localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic signed [M_W-1:0] OFFSET_LIMIT = 34'sd67108864;

    function automatic logic signed [P_W-1:0] round_shift(
        input logic signed [P_W-1:0] v,
        input int unsigned           s
    );
        logic [P_W-1:0] m;
        m = v[P_W-1] ? (64'd0 - $unsigned(v)) : $unsigned(v);
        m = (m + (64'd1 << (s - 1))) >> s;
        return v[P_W-1] ? -$signed(m) : $signed(m);
    endfunction

endpackage

// ----- sv/rppc_if.sv -----
// ----------------------------------------------------------------------------
// rppc_if
// Point and result channels of the regular polygon point clamp.
// ----------------------------------------------------------------------------
interface rppc_point_if #(
    parameter int COORD_BITS = 20
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;

    modport source (output valid, point_x, point_y, input ready);
    modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface rppc_result_if #(
    parameter int COORD_BITS = 20
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] result_x;
    logic signed [COORD_BITS-1:0] result_y;
    logic                         was_clamped;

    modport source (output valid, result_x, result_y, was_clamped, input ready);
    modport sink   (input valid, result_x, result_y, was_clamped, output ready);
endinterface

// ----- sv/regular_polygon_point_clamp_core.sv -----
// ----------------------------------------------------------------------------
// regular_polygon_point_clamp_core
// Clamps a point to the nearest boundary point of a regular elliptical polygon.
// ----------------------------------------------------------------------------
// Usage:
//   Write center, radii and corner count through cfg_we/cfg_index/cfg_data
//   while no transaction is in flight. Send points on the point channel; each
//   point yields one transaction on the result channel.
//   The point channel is ready only when the core is idle. One shared 34x34
//   multiplier and one shift-subtract divider do all the arithmetic under a
//   small sequencer: corner phase step by division (two or more corners), then
//   for each corner the cosine and sine polynomials and the phase advance, then
//   per edge the projection, which may call on the divider. With no corners a
//   point goes straight to the result channel. The next point is taken in the
//   cycle after the result. The result is held in registers until the receiver
//   takes it; a stalled receiver holds the core and the next point. Reset
//   clears the configuration registers to zero (no corners: points pass
//   unchanged) and returns the core to idle.
// ----------------------------------------------------------------------------
module regular_polygon_point_clamp_core
    import rppc_pkg::*;
#(
    parameter int MAX_CORNERS = 32,
    parameter int COORD_BITS  = 20,
    localparam int CFG_W = (COORD_BITS > R_W) ? COORD_BITS : R_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    rppc_point_if.sink       point,
    rppc_result_if.source    result
);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_DIV  = 5'd1;
    localparam logic [4:0] ST_T0   = 5'd2;
    localparam logic [4:0] ST_T1   = 5'd3;
    localparam logic [4:0] ST_T2   = 5'd4;
    localparam logic [4:0] ST_T3   = 5'd5;
    localparam logic [4:0] ST_T4   = 5'd6;
    localparam logic [4:0] ST_T5   = 5'd7;
    localparam logic [4:0] ST_T6   = 5'd8;
    localparam logic [4:0] ST_T7   = 5'd9;
    localparam logic [4:0] ST_ADV  = 5'd10;
    localparam logic [4:0] ST_E0   = 5'd11;
    localparam logic [4:0] ST_E1   = 5'd12;
    localparam logic [4:0] ST_E2   = 5'd13;
    localparam logic [4:0] ST_E3   = 5'd14;
    localparam logic [4:0] ST_E4   = 5'd15;
    localparam logic [4:0] ST_E5   = 5'd16;
    localparam logic [4:0] ST_E6   = 5'd17;
    localparam logic [4:0] ST_E7   = 5'd18;
    localparam logic [4:0] ST_E8   = 5'd19;
    localparam logic [4:0] ST_E9   = 5'd20;
    localparam logic [4:0] ST_E10  = 5'd21;
    localparam logic [4:0] ST_E11  = 5'd22;
    localparam logic [4:0] ST_E12  = 5'd23;
    localparam logic [4:0] ST_E13  = 5'd24;
    localparam logic [4:0] ST_F0   = 5'd25;
    localparam logic [4:0] ST_F1   = 5'd26;
    localparam logic [4:0] ST_F2   = 5'd27;
    localparam logic [4:0] ST_F3   = 5'd28;
    localparam logic [4:0] ST_OUT  = 5'd29;

    localparam logic signed [M_W-1:0] C_MAX =
        M_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [M_W-1:0] C_MIN = -C_MAX - 34'sd1;
    localparam logic [N_W-1:0] N_MAX = N_W'(MAX_CORNERS);

    logic [4:0]                   state_reg, state_next;
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg;
    logic [R_W-1:0]               rad_x_reg, rad_y_reg;
    logic [5:0]                   corners_reg;

    logic signed [COORD_BITS-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [D_W-1:0]        dx_reg, dx_next, dy_reg, dy_next;
    logic [N_W-1:0]               n_reg, n_next;
    logic [39:0]                  rem_reg, rem_next, dvsr_reg, dvsr_next;
    logic [31:0]                  quo_reg, quo_next;
    logic [5:0]                   it_reg, it_next;
    logic                         div_t_reg, div_t_next;
    logic [31:0]                  step_q_reg, step_q_next, phase_reg, phase_next;
    logic [N_W-1:0]               step_r_reg, step_r_next, acc_reg, acc_next;
    logic [N_W-1:0]               idx_reg, idx_next;
    logic                         first_reg, first_next, trig_y_reg, trig_y_next;
    logic [30:0]                  z_reg, z_next, z2_reg, z2_next;
    logic [1:0]                   quad_reg, quad_next;
    logic signed [16:0]           sin_reg, sin_next;
    logic signed [K_W-1:0]        ax_reg, ax_next, ay_reg, ay_next;
    logic signed [K_W-1:0]        bx_reg, bx_next, by_reg, by_next;
    logic signed [K_W-1:0]        k0x_reg, k0x_next, k0y_reg, k0y_next;
    logic signed [E_W-1:0]        ex_reg, ex_next, ey_reg, ey_next;
    logic signed [W_W-1:0]        wx_reg, wx_next, wy_reg, wy_next;
    logic signed [W_W-1:0]        ux_reg, ux_next, uy_reg, uy_next;
    logic signed [P_W-1:0]        dot_reg, dot_next, len_reg, len_next;
    logic [16:0]                  t_reg, t_next;
    logic signed [Q_W-1:0]        qx_reg, qx_next, qy_reg, qy_next;
    logic signed [Q_W-1:0]        qbx_reg, qbx_next, qby_reg, qby_next;
    logic [P_W-1:0]               best_reg, best_next;
    logic signed [COORD_BITS-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic                         flag_reg, flag_next;

    logic signed [M_W-1:0]        mul_a, mul_b;
    logic signed [2*M_W-1:0]      prod_full;
    logic signed [P_W-1:0]        prod_reg;

    logic signed [M_W-1:0]        off_x, off_y, sum_x, sum_y;
    logic [N_W-1:0]               n_sat;
    logic [40:0]                  rem_sh;
    logic                         rem_ge;
    logic [31:0]                  p_eff;
    logic [33:0]                  s_rnd;
    logic [18:0]                  s_mag;
    logic [15:0]                  s_sat;
    logic signed [K_W-1:0]        k_new;
    logic [N_W:0]                 acc_sum;
    logic                         acc_carry;
    logic [P_W-1:0]               d2;
    logic [R_W-1:0]               rmin;

    assign point.ready     = (state_reg == ST_IDLE);
    assign result.valid    = (state_reg == ST_OUT);
    assign result.result_x = rx_reg;
    assign result.result_y = ry_reg;
    assign result.was_clamped = flag_reg;

    assign rmin = (rad_x_reg < rad_y_reg) ? rad_x_reg : rad_y_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_T1:
            begin
                mul_a = M_W'(z_reg);
                mul_b = M_W'(z_reg);
            end
            ST_T2:
            begin
                mul_a = M_W'(prod_reg[60:30]);
                mul_b = M_W'(TRIG_C);
            end
            ST_T3:
            begin
                mul_a = M_W'(z2_reg);
                mul_b = M_W'(TRIG_B - prod_reg[61:30]);
            end
            ST_T4:
            begin
                mul_a = M_W'(z_reg);
                mul_b = M_W'(TRIG_A - prod_reg[61:30]);
            end
            ST_T6:
            begin
                mul_a = M_W'(trig_y_reg ? rad_y_reg : rad_x_reg);
                mul_b = M_W'(sin_reg);
            end
            ST_E1:
            begin
                mul_a = M_W'(wx_reg);
                mul_b = M_W'(ex_reg);
            end
            ST_E2:
            begin
                mul_a = M_W'(wy_reg);
                mul_b = M_W'(ey_reg);
            end
            ST_E3:
            begin
                mul_a = M_W'(ex_reg);
                mul_b = M_W'(ex_reg);
            end
            ST_E4:
            begin
                mul_a = M_W'(ey_reg);
                mul_b = M_W'(ey_reg);
            end
            ST_E7:
            begin
                mul_a = M_W'(ex_reg);
                mul_b = M_W'(t_reg);
            end
            ST_E8:
            begin
                mul_a = M_W'(ey_reg);
                mul_b = M_W'(t_reg);
            end
            ST_E11:
            begin
                mul_a = M_W'(ux_reg);
                mul_b = M_W'(ux_reg);
            end
            ST_E12:
            begin
                mul_a = M_W'(uy_reg);
                mul_b = M_W'(uy_reg);
            end
            ST_F0:
            begin
                mul_a = M_W'(dx_reg);
                mul_b = M_W'(dx_reg);
            end
            ST_F1:
            begin
                mul_a = M_W'(dy_reg);
                mul_b = M_W'(dy_reg);
            end
            ST_F2:
            begin
                mul_a = M_W'(rmin);
                mul_b = M_W'(rmin);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    always_comb
    begin
        off_x = M_W'(point.point_x) - M_W'(cx_reg);
        off_y = M_W'(point.point_y) - M_W'(cy_reg);
        if (off_x > OFFSET_LIMIT)
            off_x = OFFSET_LIMIT;
        else if (off_x < -OFFSET_LIMIT)
            off_x = -OFFSET_LIMIT;
        if (off_y > OFFSET_LIMIT)
            off_y = OFFSET_LIMIT;
        else if (off_y < -OFFSET_LIMIT)
            off_y = -OFFSET_LIMIT;
        n_sat = ({1'b0, corners_reg} > N_MAX) ? N_MAX : {1'b0, corners_reg};

        rem_sh = {rem_reg, 1'b0};
        rem_ge = (rem_sh >= {1'b0, dvsr_reg});

        p_eff = phase_reg + (trig_y_reg ? 32'd0 : QUARTER_TURN);

        s_rnd = prod_reg[63:30] + 34'd16384;
        s_mag = s_rnd[33:15];
        s_sat = (s_mag > 19'd32767) ? 16'd32767 : s_mag[15:0];

        k_new = K_W'(round_shift(prod_reg, 15));

        acc_sum   = {1'b0, acc_reg} + {1'b0, step_r_reg};
        acc_carry = (acc_sum >= {1'b0, n_reg});

        d2 = $unsigned(dot_reg) + $unsigned(prod_reg);

        sum_x = M_W'(cx_reg) + M_W'(qbx_reg);
        sum_y = M_W'(cy_reg) + M_W'(qby_reg);
        if (sum_x > C_MAX)
            sum_x = C_MAX;
        else if (sum_x < C_MIN)
            sum_x = C_MIN;
        if (sum_y > C_MAX)
            sum_y = C_MAX;
        else if (sum_y < C_MIN)
            sum_y = C_MIN;
    end

    always_comb
    begin
        state_next  = state_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        n_next      = n_reg;
        rem_next    = rem_reg;
        dvsr_next   = dvsr_reg;
        quo_next    = quo_reg;
        it_next     = it_reg;
        div_t_next  = div_t_reg;
        step_q_next = step_q_reg;
        step_r_next = step_r_reg;
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        idx_next    = idx_reg;
        first_next  = first_reg;
        trig_y_next = trig_y_reg;
        z_next      = z_reg;
        z2_next     = z2_reg;
        quad_next   = quad_reg;
        sin_next    = sin_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        bx_next     = bx_reg;
        by_next     = by_reg;
        k0x_next    = k0x_reg;
        k0y_next    = k0y_reg;
        ex_next     = ex_reg;
        ey_next     = ey_reg;
        wx_next     = wx_reg;
        wy_next     = wy_reg;
        ux_next     = ux_reg;
        uy_next     = uy_reg;
        dot_next    = dot_reg;
        len_next    = len_reg;
        t_next      = t_reg;
        qx_next     = qx_reg;
        qy_next     = qy_reg;
        qbx_next    = qbx_reg;
        qby_next    = qby_reg;
        best_next   = best_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        flag_next   = flag_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (point.valid)
                begin
                    px_next     = point.point_x;
                    py_next     = point.point_y;
                    dx_next     = D_W'(off_x);
                    dy_next     = D_W'(off_y);
                    n_next      = n_sat;
                    step_q_next = '0;
                    step_r_next = '0;
                    phase_next  = '0;
                    acc_next    = '0;
                    idx_next    = '0;
                    first_next  = 1'b1;
                    trig_y_next = 1'b0;
                    if (n_sat == '0)
                    begin
                        rx_next    = point.point_x;
                        ry_next    = point.point_y;
                        flag_next  = 1'b0;
                        state_next = ST_OUT;
                    end
                    else if (n_sat == N_W'(1))
                    begin
                        state_next = ST_T0;
                    end
                    else
                    begin
                        rem_next   = 40'd1;
                        dvsr_next  = 40'(n_sat);
                        quo_next   = '0;
                        it_next    = 6'd32;
                        div_t_next = 1'b0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = rem_ge ? 40'(rem_sh - {1'b0, dvsr_reg}) : rem_sh[39:0];
                quo_next = {quo_reg[30:0], rem_ge};
                it_next  = it_reg - 6'd1;
                if (it_reg == 6'd1)
                begin
                    if (div_t_reg)
                    begin
                        t_next     = quo_next[16:0];
                        state_next = ST_E7;
                    end
                    else
                    begin
                        step_q_next = quo_next;
                        step_r_next = rem_next[N_W-1:0];
                        state_next  = ST_T0;
                    end
                end
            end
            ST_T0:
            begin
                quad_next  = p_eff[31:30];
                z_next     = p_eff[30] ? (Q30_ONE - {1'b0, p_eff[29:0]})
                                       : {1'b0, p_eff[29:0]};
                state_next = ST_T1;
            end
            ST_T1:
            begin
                state_next = ST_T2;
            end
            ST_T2:
            begin
                z2_next    = prod_reg[60:30];
                state_next = ST_T3;
            end
            ST_T3:
            begin
                state_next = ST_T4;
            end
            ST_T4:
            begin
                state_next = ST_T5;
            end
            ST_T5:
            begin
                sin_next   = quad_reg[1] ? -$signed({1'b0, s_sat}) : $signed({1'b0, s_sat});
                state_next = ST_T6;
            end
            ST_T6:
            begin
                state_next = ST_T7;
            end
            ST_T7:
            begin
                if (!trig_y_reg)
                begin
                    bx_next     = k_new;
                    trig_y_next = 1'b1;
                    state_next  = ST_T0;
                end
                else
                begin
                    by_next = k_new;
                    if (first_reg)
                    begin
                        k0x_next   = bx_reg;
                        k0y_next   = k_new;
                        ax_next    = bx_reg;
                        ay_next    = k_new;
                        first_next = 1'b0;
                        state_next = ST_ADV;
                    end
                    else
                    begin
                        state_next = ST_E0;
                    end
                end
            end
            ST_ADV:
            begin
                acc_next    = acc_carry ? N_W'(acc_sum - {1'b0, n_reg}) : acc_sum[N_W-1:0];
                phase_next  = phase_reg + step_q_reg + {31'd0, acc_carry};
                trig_y_next = 1'b0;
                if (idx_reg + N_W'(1) == n_reg)
                begin
                    bx_next    = k0x_reg;
                    by_next    = k0y_reg;
                    state_next = ST_E0;
                end
                else
                begin
                    state_next = ST_T0;
                end
            end
            ST_E0:
            begin
                ex_next    = E_W'(bx_reg) - E_W'(ax_reg);
                ey_next    = E_W'(by_reg) - E_W'(ay_reg);
                wx_next    = W_W'(dx_reg) - W_W'(ax_reg);
                wy_next    = W_W'(dy_reg) - W_W'(ay_reg);
                state_next = ST_E1;
            end
            ST_E1:
            begin
                state_next = ST_E2;
            end
            ST_E2:
            begin
                dot_next   = prod_reg;
                state_next = ST_E3;
            end
            ST_E3:
            begin
                dot_next   = dot_reg + prod_reg;
                state_next = ST_E4;
            end
            ST_E4:
            begin
                len_next   = prod_reg;
                state_next = ST_E5;
            end
            ST_E5:
            begin
                len_next   = len_reg + prod_reg;
                state_next = ST_E6;
            end
            ST_E6:
            begin
                if (len_reg == '0 || dot_reg <= 64'sd0)
                begin
                    t_next     = '0;
                    state_next = ST_E7;
                end
                else if (dot_reg >= len_reg)
                begin
                    t_next     = 17'd65536;
                    state_next = ST_E7;
                end
                else
                begin
                    rem_next   = dot_reg[39:0];
                    dvsr_next  = len_reg[39:0];
                    quo_next   = '0;
                    it_next    = 6'd16;
                    div_t_next = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_E7:
            begin
                state_next = ST_E8;
            end
            ST_E8:
            begin
                qx_next    = Q_W'(ax_reg) + Q_W'(round_shift(prod_reg, 16));
                state_next = ST_E9;
            end
            ST_E9:
            begin
                qy_next    = Q_W'(ay_reg) + Q_W'(round_shift(prod_reg, 16));
                state_next = ST_E10;
            end
            ST_E10:
            begin
                ux_next    = W_W'(dx_reg) - W_W'(qx_reg);
                uy_next    = W_W'(dy_reg) - W_W'(qy_reg);
                state_next = ST_E11;
            end
            ST_E11:
            begin
                state_next = ST_E12;
            end
            ST_E12:
            begin
                dot_next   = prod_reg;
                state_next = ST_E13;
            end
            ST_E13:
            begin
                if (idx_reg == '0 || d2 < best_reg)
                begin
                    best_next = d2;
                    qbx_next  = qx_reg;
                    qby_next  = qy_reg;
                end
                ax_next  = bx_reg;
                ay_next  = by_reg;
                idx_next = idx_reg + N_W'(1);
                if (idx_reg + N_W'(1) == n_reg)
                    state_next = ST_F0;
                else
                    state_next = ST_ADV;
            end
            ST_F0:
            begin
                state_next = ST_F1;
            end
            ST_F1:
            begin
                dot_next   = prod_reg;
                state_next = ST_F2;
            end
            ST_F2:
            begin
                dot_next   = dot_reg + prod_reg;
                state_next = ST_F3;
            end
            ST_F3:
            begin
                if ($unsigned(dot_reg) > $unsigned(prod_reg))
                begin
                    rx_next   = COORD_BITS'(sum_x);
                    ry_next   = COORD_BITS'(sum_y);
                    flag_next = 1'b1;
                end
                else
                begin
                    rx_next   = px_reg;
                    ry_next   = py_reg;
                    flag_next = 1'b0;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (result.ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cx_reg      <= '0;
            cy_reg      <= '0;
            rad_x_reg   <= '0;
            rad_y_reg   <= '0;
            corners_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CENTER_X: cx_reg      <= cfg_data[COORD_BITS-1:0];
                    REG_CENTER_Y: cy_reg      <= cfg_data[COORD_BITS-1:0];
                    REG_RADIUS_X: rad_x_reg   <= cfg_data[R_W-1:0];
                    REG_RADIUS_Y: rad_y_reg   <= cfg_data[R_W-1:0];
                    REG_CORNERS:  corners_reg <= cfg_data[5:0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= $signed(prod_full[P_W-1:0]);
        px_reg     <= px_next;
        py_reg     <= py_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        n_reg      <= n_next;
        rem_reg    <= rem_next;
        dvsr_reg   <= dvsr_next;
        quo_reg    <= quo_next;
        it_reg     <= it_next;
        div_t_reg  <= div_t_next;
        step_q_reg <= step_q_next;
        step_r_reg <= step_r_next;
        phase_reg  <= phase_next;
        acc_reg    <= acc_next;
        idx_reg    <= idx_next;
        first_reg  <= first_next;
        trig_y_reg <= trig_y_next;
        z_reg      <= z_next;
        z2_reg     <= z2_next;
        quad_reg   <= quad_next;
        sin_reg    <= sin_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
        k0x_reg    <= k0x_next;
        k0y_reg    <= k0y_next;
        ex_reg     <= ex_next;
        ey_reg     <= ey_next;
        wx_reg     <= wx_next;
        wy_reg     <= wy_next;
        ux_reg     <= ux_next;
        uy_reg     <= uy_next;
        dot_reg    <= dot_next;
        len_reg    <= len_next;
        t_reg      <= t_next;
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        qbx_reg    <= qbx_next;
        qby_reg    <= qby_next;
        best_reg   <= best_next;
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        flag_reg   <= flag_next;
    end

endmodule
